// File: rtl/rfft_pkg.sv
// Shared constants, status types and coefficient helpers for the 16-point real FFT.
`default_nettype none
package rfft_pkg;

  localparam int SAMPLE_WIDTH_DEF   = 16;
  localparam int COEF_FRAC_BITS_DEF = 16;
  localparam int POINTS             = 16;
  localparam int IDX_W              = 4;
  localparam int VAL_W              = 20;

  localparam longint VAL_MAX = 64'sd524287;
  localparam longint VAL_MIN = -64'sd524288;

  localparam longint Q30_SIN_1 = 64'sd410903207;
  localparam longint Q30_SIN_2 = 64'sd759250125;
  localparam longint Q30_SIN_3 = 64'sd992008094;
  localparam longint Q30_CPS   = 64'sd1402911301;
  localparam longint Q30_CMS   = 64'sd581104887;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic longint coef_q(input longint q30, input int frac);
    longint r;
    r = (q30 + (64'sd1 <<< (29 - frac))) >>> (30 - frac);
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/rfft_front.sv
// Sample collector: counts samples and hands each full block of sixteen to the queue.
`default_nettype none
module rfft_front #(
  parameter int SAMPLE_WIDTH = rfft_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic [SAMPLE_WIDTH-1:0]               sample,
  input  wire logic                                  push,
  output logic                                       full,
  output logic                                       q_push,
  output logic [rfft_pkg::POINTS*SAMPLE_WIDTH-1:0]   q_data,
  input  wire rfft_pkg::q_status_t                   qs
);
  import rfft_pkg::*;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(POINTS - 1);

  logic [IDX_W-1:0]        fill_count;
  logic [SAMPLE_WIDTH-1:0] shreg [POINTS];
  logic                    accept;

  assign full   = (fill_count == LAST) && qs.full;
  assign accept = push && !full;
  assign q_push = accept && (fill_count == LAST);

  always_comb begin
    for (int n = 0; n < POINTS - 1; n++) begin
      q_data[n*SAMPLE_WIDTH +: SAMPLE_WIDTH] = shreg[n+1];
    end
    q_data[(POINTS-1)*SAMPLE_WIDTH +: SAMPLE_WIDTH] = sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (accept) begin
      fill_count <= fill_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int n = 0; n < POINTS - 1; n++) begin
        shreg[n] <= shreg[n+1];
      end
      shreg[POINTS-1] <= sample;
    end
  end

endmodule
`default_nettype wire

// File: rtl/rfft_queue.sv
// Two-entry block queue between the collector and the transform engine.
`default_nettype none
module rfft_queue #(
  parameter int BW = rfft_pkg::POINTS * rfft_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr,
  input  wire logic [BW-1:0]   wr_data,
  input  wire logic            rd,
  output logic [BW-1:0]        rd_data,
  output rfft_pkg::q_status_t  qs
);
  import rfft_pkg::*;

  logic [BW-1:0] mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          do_wr;
  logic          do_rd;

  assign qs.full  = (count == 2'd2);
  assign qs.empty = (count == 2'd0);
  assign do_wr    = wr && !qs.full;
  assign do_rd    = rd && !qs.empty;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= ~wr_ptr;
      if (do_rd) rd_ptr <= ~rd_ptr;
      if (do_wr && !do_rd) begin
        count <= count + 2'd1;
      end else if (do_rd && !do_wr) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

endmodule
`default_nettype wire

// File: rtl/rfft_back.sv
// Transform engine: three pipeline steps per block, then a sixteen-word output shifter.
`default_nettype none
module rfft_back #(
  parameter int SAMPLE_WIDTH   = rfft_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = rfft_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic [rfft_pkg::POINTS*SAMPLE_WIDTH-1:0] q_data,
  input  wire rfft_pkg::q_status_t                   qs,
  output logic                                       q_pop,
  output logic [rfft_pkg::IDX_W-1:0]                 word_index,
  output logic signed [rfft_pkg::VAL_W-1:0]          value,
  output logic                                       final_word,
  output logic                                       empty,
  input  wire logic                                  pop
);
  import rfft_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int CF = COEF_FRAC_BITS;
  localparam int W  = SW + 6;
  localparam int KW = CF + 2;
  localparam int PW = W + KW;
  localparam int SV = W + VAL_W;

  localparam logic signed [KW-1:0] KS1 = KW'(coef_q(Q30_SIN_1, CF));
  localparam logic signed [KW-1:0] KS2 = KW'(coef_q(Q30_SIN_2, CF));
  localparam logic signed [KW-1:0] KS3 = KW'(coef_q(Q30_SIN_3, CF));
  localparam logic signed [KW-1:0] KP  = KW'(coef_q(Q30_CPS, CF));
  localparam logic signed [KW-1:0] KM  = KW'(coef_q(Q30_CMS, CF));
  localparam logic signed [SV-1:0] VMAX = SV'(VAL_MAX);
  localparam logic signed [SV-1:0] VMIN = SV'(VAL_MIN);
  localparam logic [IDX_W-1:0]     LAST = IDX_W'(POINTS - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_BFLY = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;

  function automatic logic signed [W-1:0] cmul(input logic signed [W-1:0] x,
                                               input logic signed [KW-1:0] c);
    logic signed [PW-1:0] p;
    p = x * c;
    p = p + {{(PW-CF){1'b0}}, 1'b1, {(CF-1){1'b0}}};
    return p[CF+W-1:CF];
  endfunction

  function automatic logic signed [VAL_W-1:0] sat(input logic signed [W-1:0] v);
    logic signed [SV-1:0] e;
    e = SV'(v);
    if (e > VMAX) e = VMAX;
    if (e < VMIN) e = VMIN;
    return e[VAL_W-1:0];
  endfunction

  logic [2:0] state;
  logic [2:0] state_next;
  logic [IDX_W-1:0] idx;

  logic signed [W-1:0] x [POINTS];
  logic signed [W-1:0] e [8];
  logic signed [W-1:0] b [8:15];
  logic signed [W-1:0] d13_9, d15_11;
  logic signed [W-1:0] t1, t3, p9, p10, p11, p13, p14, p15, q5, q7;
  logic signed [W-1:0] b8m, b12m, e0m, e1m, e2m, e3m, e4m, e6m;
  logic signed [W-1:0] o [POINTS];
  logic signed [VAL_W-1:0] obuf [POINTS];

  logic signed [W-1:0] bb9, bb10, bb11, bb13, bb14, bb15;
  logic signed [W-1:0] c8, c9, c10, c11, c12, c13, c14, c15;
  logic signed [W-1:0] o0r, a1n, sp, sm;

  assign q_pop      = (state == ST_IDLE) && !qs.empty;
  assign empty      = (state != ST_EMIT);
  assign value      = obuf[0];
  assign word_index = idx;
  assign final_word = (idx == LAST);

  always_comb begin
    for (int n = 0; n < POINTS; n++) begin
      x[n] = W'(signed'(q_data[n*SW +: SW]));
    end
  end

  always_comb begin
    bb9  = p9 + t1;
    bb13 = p13 + t1;
    bb10 = p14 + p10;
    bb14 = p14 - p10;
    bb11 = p11 + t3;
    bb15 = t3 - p15;
    c8   = b8m + bb10;
    c10  = b8m - bb10;
    c12  = b12m + bb14;
    c14  = b12m - bb14;
    c9   = bb9 + bb11;
    c11  = bb9 - bb11;
    c13  = bb13 + bb15;
    c15  = bb13 - bb15;
    o0r  = e0m + e2m;
    a1n  = e1m + e3m;
    sp   = q5 + q7;
    sm   = q5 - q7;
    o[0]  = o0r + a1n;
    o[1]  = c8 + c9;
    o[2]  = sm + e4m;
    o[3]  = c10 - c15;
    o[4]  = e0m - e2m;
    o[5]  = c10 + c15;
    o[6]  = e4m - sm;
    o[7]  = c8 - c9;
    o[8]  = o0r - a1n;
    o[9]  = c12 + c13;
    o[10] = -sp - e6m;
    o[11] = -c14 - c11;
    o[12] = e3m - e1m;
    o[13] = c14 - c11;
    o[14] = e6m - sp;
    o[15] = c13 - c12;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (!qs.empty) state_next = ST_MUL;
      ST_MUL:  state_next = ST_BFLY;
      ST_BFLY: state_next = ST_EMIT;
      ST_EMIT: if (pop && idx == LAST) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_BFLY) begin
        idx <= '0;
      end else if (state == ST_EMIT && pop) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int n = 0; n < 4; n++) begin
        e[n]   <= (x[n] + x[n+8]) + (x[n+4] + x[n+12]);
        e[n+4] <= (x[n] + x[n+8]) - (x[n+4] + x[n+12]);
        b[8+n]  <= x[n] - x[n+8];
        b[12+n] <= x[n+12] - x[n+4];
      end
      d13_9  <= (x[13] - x[5]) - (x[1] - x[9]);
      d15_11 <= (x[15] - x[7]) - (x[3] - x[11]);
    end
    if (state == ST_MUL) begin
      t1   <= cmul(d13_9, KS1);
      p9   <= cmul(b[9], KP);
      p13  <= cmul(b[13], KM);
      p14  <= cmul(b[14], KS2);
      p10  <= cmul(b[10], KS2);
      t3   <= cmul(d15_11, KS3);
      p11  <= cmul(b[11], KP);
      p15  <= cmul(b[15], KM);
      q5   <= cmul(e[5], KS2);
      q7   <= cmul(e[7], KS2);
      b8m  <= b[8];
      b12m <= b[12];
      e0m  <= e[0];
      e1m  <= e[1];
      e2m  <= e[2];
      e3m  <= e[3];
      e4m  <= e[4];
      e6m  <= e[6];
    end
    if (state == ST_BFLY) begin
      for (int n = 0; n < POINTS; n++) begin
        obuf[n] <= sat(o[n]);
      end
    end else if (state == ST_EMIT && pop) begin
      for (int n = 0; n < POINTS - 1; n++) begin
        obuf[n] <= obuf[n+1];
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/real_fft_16_point.sv
// Top level of the 16-point split-radix real FFT: collector, block queue, transform engine.
//
//   channel  | handshake     | words
//   ---------+---------------+-----------------------------------------
//   input    | push / full   | sample
//   result   | pop / empty   | word_index, value, final_word
//
// Sixteen samples are taken one per cycle while full is low; the sixteenth moves the block into a
// two-entry queue. The engine works on a block in order (sums, products,
// butterflies), then offers sixteen words, one per cycle while pop is high.
// Reset clears the sample count, the queue and the engine state.
// full rises only on a sixteenth sample while both queue entries are taken;
// a stalled result side holds the engine and fills the queue.
`default_nettype none
module real_fft_16_point #(
  parameter int SAMPLE_WIDTH   = rfft_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = rfft_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [SAMPLE_WIDTH-1:0]       sample,
  input  wire logic                          push,
  output logic                               full,
  output logic [rfft_pkg::IDX_W-1:0]         word_index,
  output logic signed [rfft_pkg::VAL_W-1:0]  value,
  output logic                               final_word,
  output logic                               empty,
  input  wire logic                          pop
);
  import rfft_pkg::*;

  localparam int BW = POINTS * SAMPLE_WIDTH;

  logic          q_push;
  logic          q_pop;
  logic [BW-1:0] q_wdata;
  logic [BW-1:0] q_rdata;
  q_status_t     qs;

  rfft_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
    .clk    (clk),
    .rst    (rst),
    .sample (sample),
    .push   (push),
    .full   (full),
    .q_push (q_push),
    .q_data (q_wdata),
    .qs     (qs)
  );

  rfft_queue #(.BW(BW)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (q_wdata),
    .rd      (q_pop),
    .rd_data (q_rdata),
    .qs      (qs)
  );

  rfft_back #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_data     (q_rdata),
    .qs         (qs),
    .q_pop      (q_pop),
    .word_index (word_index),
    .value      (value),
    .final_word (final_word),
    .empty      (empty),
    .pop        (pop)
  );

endmodule
`default_nettype wire

// File: tb/real_fft_16_point_test.sv
// Testbench for the 16-point real FFT: directed and random sample blocks checked against a predictor.
module real_fft_16_point_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rfft_pkg::*;

  typedef struct {
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] val;
    logic                    fin;
  } spec_word_t;

  class spectrum_board;
    longint samples [16];
    int unsigned fill;
    spec_word_t pending [$];
    int errors;
    int words_seen;

    function longint rmul(longint x, longint c);
      longint p;
      p = x * c + (64'sd1 <<< 15);
      return p >>> 16;
    endfunction

    function longint clamp(longint v);
      if (v > VAL_MAX) return VAL_MAX;
      if (v < VAL_MIN) return VAL_MIN;
      return v;
    endfunction

    function void note_sample(logic signed [15:0] s);
      longint a [8];
      longint b [16];
      longint o [16];
      longint t, u, k1, k2, k3, kp, km;
      spec_word_t w;
      samples[fill] = longint'(s);
      fill = (fill + 1) % 16;
      if (fill != 0) return;
      k1 = (Q30_SIN_1 + (64'sd1 <<< 13)) >>> 14;
      k2 = (Q30_SIN_2 + (64'sd1 <<< 13)) >>> 14;
      k3 = (Q30_SIN_3 + (64'sd1 <<< 13)) >>> 14;
      kp = (Q30_CPS + (64'sd1 <<< 13)) >>> 14;
      km = (Q30_CMS + (64'sd1 <<< 13)) >>> 14;
      for (int n = 0; n < 8; n++) a[n] = samples[n] + samples[n+8];
      for (int n = 0; n < 4; n++) begin
        b[8+n] = samples[n] - samples[n+8];
        b[12+n] = samples[n+12] - samples[n+4];
      end
      t = rmul(b[13] - b[9], k1);
      b[9] = rmul(b[9], kp) + t;
      b[13] = rmul(b[13], km) + t;
      b[14] = rmul(b[14], k2);
      b[10] = rmul(b[10], k2);
      u = b[14] - b[10]; b[10] = b[14] + b[10]; b[14] = u;
      t = rmul(b[15] - b[11], k3);
      b[11] = rmul(b[11], kp) + t;
      b[15] = -rmul(b[15], km) + t;
      u = b[8];  b[8] = u + b[10];  b[10] = u - b[10];
      u = b[12]; b[12] = u + b[14]; b[14] = u - b[14];
      u = b[9];  b[9] = u + b[11];  b[11] = u - b[11];
      u = b[13]; b[13] = u + b[15]; b[15] = u - b[15];
      o[1] = b[8] + b[9];   o[7] = b[8] - b[9];
      o[9] = b[12] + b[13]; o[15] = b[13] - b[12];
      o[5] = b[10] + b[15]; o[13] = b[14] - b[11];
      o[3] = b[10] - b[15]; o[11] = -b[14] - b[11];
      for (int n = 0; n < 4; n++) begin
        u = a[n]; a[n] = u + a[n+4]; a[n+4] = u - a[n+4];
      end
      o[0] = a[0] + a[2]; o[4] = a[0] - a[2];
      a[1] = a[1] + a[3];
      o[12] = a[3] + a[3] - a[1];
      o[0] = o[0] + a[1];
      o[8] = o[0] - a[1] - a[1];
      a[5] = rmul(a[5], k2); a[7] = rmul(a[7], k2);
      u = a[5] - a[7]; a[7] = a[5] + a[7]; a[5] = u;
      o[14] = a[6] - a[7]; o[2] = a[5] + a[4];
      o[6] = a[4] - a[5];  o[10] = -a[7] - a[6];
      for (int n = 0; n < 16; n++) begin
        w.idx = IDX_W'(n);
        w.val = VAL_W'(clamp(o[n]));
        w.fin = (n == 15);
        pending.push_back(w);
      end
    endfunction

    function void check_word(logic [IDX_W-1:0] idx, logic signed [VAL_W-1:0] val,
                             logic fin);
      spec_word_t w;
      words_seen++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word idx %0d value %0d", $time, idx, val);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (idx !== w.idx) begin
        $display("%0t: word_index expected %0d actual %0d", $time, w.idx, idx);
        errors++;
      end
      if (val !== w.val) begin
        $display("%0t: value[%0d] expected %0d actual %0d", $time, w.idx, w.val, val);
        errors++;
      end
      if (fin !== w.fin) begin
        $display("%0t: final_word[%0d] expected %0d actual %0d", $time, w.idx, w.fin, fin);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst, push, pop;
  logic [15:0] sample;
  logic full, empty, final_word;
  logic [IDX_W-1:0] word_index;
  logic signed [VAL_W-1:0] value;
  spectrum_board board;
  int cycles;
  bit pop_quiet;

  real_fft_16_point dut (
    .clk(clk), .rst(rst), .sample(sample), .push(push), .full(full),
    .word_index(word_index), .value(value), .final_word(final_word),
    .empty(empty), .pop(pop)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(5, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: accept and randomly stall, except while pop_quiet is set
  initial begin
    int g;
    pop = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (pop && !empty) board.check_word(word_index, value, final_word);
      if (g > 0) begin
        g--;
        pop <= 0;
      end else if (pop_quiet) begin
        pop <= 1;
      end else begin
        g = gap_len();
        pop <= (g == 0);
      end
    end
  end

  task automatic send_sample(logic [15:0] s, bit no_gap);
    int g;
    g = no_gap ? 0 : gap_len();
    repeat (g) begin
      @(posedge clk);
      push <= 0;
    end
    @(posedge clk);
    push <= 1;
    sample <= s;
    do @(posedge clk); while (full);
    board.note_sample(s);
    push <= 0;
  endtask

  task automatic send_block(int kind, bit no_gap);
    logic [15:0] s;
    for (int n = 0; n < 16; n++) begin
      case (kind)
        0: s = 16'h7fff;
        1: s = 16'h8000;
        2: s = n[0] ? 16'h8000 : 16'h7fff;
        3: s = (n == 0) ? 16'h7fff : 16'h0000;
        4: s = n[1] ? 16'h8000 : 16'h7fff;
        5: s = 16'($urandom_range(0, 7) - 4);
        default: s = 16'($urandom());
      endcase
      send_sample(s, no_gap);
    end
  endtask

  initial begin
    board = new();
    pop_quiet = 0;
    rst = 1;
    push = 0;
    sample = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    for (int k = 0; k < 5; k++) send_block(k, 0);
    // hold off until the engine drains
    while (board.pending.size() != 0) @(posedge clk);
    for (int k = 0; k < 3; k++) send_block(k == 0 ? 5 : 6, k == 1);
    pop_quiet = 1;
    for (int k = 0; k < 2; k++) send_block(6, 1);
    pop_quiet = 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("Covered %0d blocks: extremes, impulse, alternating, small and random samples.",
             10);
    $display("Checked %0d spectrum words with random stalls on both sides.", board.words_seen);
    if (board.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
